// ----- design/hfe_pkg.sv -----
package hfe_pkg;

  localparam int unsigned MaxFieldsDef    = 8;
  localparam int unsigned MaxFieldBytesDef = 8;
  localparam int unsigned SizeBitsDef     = 32;

  localparam int unsigned NumFieldSlots = 8;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIELD_COUNT = 2'd0,
    CFG_FIELD_LENGTHS = 2'd1,
    CFG_TEXT_MASK = 2'd2,
    CFG_SIZE_INDEX = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_NUMERIC = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_PAYLOAD = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    CMD_ACC = 2'd0,
    CMD_NUM = 2'd1,
    CMD_TEXT = 2'd2,
    CMD_PAY = 2'd3
  } cmd_op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [2:0]  field_index;
    logic [63:0] value;
    logic [31:0] payload_length;
    logic        length_error;
    logic        end_of_packet;
  } out_item_t;

  typedef struct packed {
    cmd_op_e     op;
    logic        fresh;
    logic [2:0]  field_index;
    logic [7:0]  data;
    logic [31:0] payload_length;
    logic        length_error;
    logic        end_of_packet;
  } cmd_t;

endpackage

// ----- design/hfe_front.sv -----
module hfe_front import hfe_pkg::*; #(
  parameter int unsigned MAX_FIELDS      = MaxFieldsDef,
  parameter int unsigned MAX_FIELD_BYTES = MaxFieldBytesDef,
  parameter int unsigned SIZE_BITS       = SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  localparam int unsigned HW = $clog2(MAX_FIELDS * MAX_FIELD_BYTES + 1);

  logic [3:0]           field_count_q;
  logic [31:0]          field_lengths_q;
  logic [7:0]           text_mask_q;
  logic [2:0]           size_idx_q;

  logic                 in_pay_q, in_pay_d;
  logic [2:0]           cf_q, cf_d;
  logic [3:0]           bif_q, bif_d;
  logic [SIZE_BITS-1:0] tsz_q, tsz_d;
  logic [SIZE_BITS-1:0] prem_q, prem_d;
  logic [SIZE_BITS-1:0] sacc_q, sacc_d;

  logic                 accept;
  logic                 start;
  logic                 in_pay;
  logic [2:0]           cf;
  logic [3:0]           bif;
  logic [SIZE_BITS-1:0] tsz, prem, sacc;
  logic [3:0]           n;
  logic [3:0]           flen [NumFieldSlots];
  logic [HW-1:0]        hlen;
  logic [SIZE_BITS-1:0] hlen_ext;
  logic [2:0]           cur;
  logic                 found, found_next;
  logic                 hdr;
  logic [3:0]           bif1;
  logic                 done;
  logic                 is_text;
  logic [SIZE_BITS-1:0] sacc_base, sacc_new, tsz_new, tsz_fin;
  logic                 fin_err;
  logic [SIZE_BITS-1:0] fin_prem, prem_base;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = cmd_ready_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_count_q   <= 4'd1;
      field_lengths_q <= 32'd4;
      text_mask_q     <= '0;
      size_idx_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FIELD_COUNT:   field_count_q   <= cfg_data_i[3:0];
        CFG_FIELD_LENGTHS: field_lengths_q <= cfg_data_i[31:0];
        CFG_TEXT_MASK:     text_mask_q     <= cfg_data_i[7:0];
        CFG_SIZE_INDEX:    size_idx_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pay_q <= 1'b0;
      cf_q     <= '0;
      bif_q    <= '0;
      tsz_q    <= '0;
      prem_q   <= '0;
      sacc_q   <= '0;
    end else begin
      in_pay_q <= in_pay_d;
      cf_q     <= cf_d;
      bif_q    <= bif_d;
      tsz_q    <= tsz_d;
      prem_q   <= prem_d;
      sacc_q   <= sacc_d;
    end
  end

  // effective field count, clamped lengths and header length
  always_comb begin
    if (field_count_q == 4'd0) begin
      n = 4'd1;
    end else if (field_count_q > 4'(MAX_FIELDS)) begin
      n = 4'(MAX_FIELDS);
    end else begin
      n = field_count_q;
    end
    hlen = '0;
    for (int i = 0; i < NumFieldSlots; i++) begin
      flen[i] = field_lengths_q[4*i +: 4];
      if (flen[i] > 4'(MAX_FIELD_BYTES)) begin
        flen[i] = 4'(MAX_FIELD_BYTES);
      end
      if (4'(i) < n) begin
        hlen = hlen + HW'(flen[i]);
      end
    end
    hlen_ext = SIZE_BITS'(hlen);
  end

  always_comb begin
    start  = in_item_i.start_packet;
    in_pay = start ? 1'b0 : in_pay_q;
    cf     = start ? '0 : cf_q;
    bif    = start ? '0 : bif_q;
    tsz    = start ? '0 : tsz_q;
    prem   = start ? '0 : prem_q;
    sacc   = start ? '0 : sacc_q;

    found = 1'b0;
    cur   = '0;
    for (int i = NumFieldSlots - 1; i >= 0; i--) begin
      if (3'(i) >= cf && 4'(i) < n && flen[i] != 4'd0) begin
        found = 1'b1;
        cur   = 3'(i);
      end
    end
    found_next = 1'b0;
    for (int i = NumFieldSlots - 1; i >= 0; i--) begin
      if (3'(i) > cur && 4'(i) < n && flen[i] != 4'd0) begin
        found_next = 1'b1;
      end
    end

    hdr       = !in_pay && found;
    is_text   = text_mask_q[cur];
    bif1      = bif + 4'd1;
    done      = (bif1 == 4'd0) || (bif1 >= flen[cur]);
    sacc_base = (bif == 4'd0) ? '0 : sacc;
    sacc_new  = (sacc_base << 8) | SIZE_BITS'(in_item_i.data_byte);
    tsz_new   = (cur == size_idx_q) ? sacc_new : tsz;
    tsz_fin   = (hdr && done) ? tsz_new : tsz;
    fin_err   = tsz_fin < hlen_ext;
    fin_prem  = fin_err ? '0 : tsz_fin - hlen_ext;
    prem_base = in_pay ? prem : fin_prem;

    in_pay_d = in_pay_q;
    cf_d     = cf_q;
    bif_d    = bif_q;
    tsz_d    = tsz_q;
    prem_d   = prem_q;
    sacc_d   = sacc_q;

    cmd_valid_o          = 1'b0;
    cmd_o.op             = CMD_PAY;
    cmd_o.fresh          = bif == 4'd0;
    cmd_o.field_index    = '0;
    cmd_o.data           = in_item_i.data_byte;
    cmd_o.payload_length = '0;
    cmd_o.length_error   = 1'b0;
    cmd_o.end_of_packet  = 1'b0;

    if (accept) begin
      in_pay_d = in_pay;
      cf_d     = cf;
      bif_d    = bif;
      tsz_d    = tsz;
      prem_d   = prem;
      sacc_d   = sacc;
      if (hdr) begin
        cmd_valid_o       = 1'b1;
        cmd_o.field_index = cur;
        if (is_text) begin
          cmd_o.op = CMD_TEXT;
        end else if (done) begin
          cmd_o.op = CMD_NUM;
        end else begin
          cmd_o.op = CMD_ACC;
        end
        if (done) begin
          sacc_d = '0;
          bif_d  = '0;
          tsz_d  = tsz_new;
          if (!found_next) begin
            in_pay_d             = 1'b1;
            cf_d                 = '0;
            prem_d               = fin_prem;
            cmd_o.payload_length = 32'(fin_prem);
            cmd_o.length_error   = fin_err;
            cmd_o.end_of_packet  = fin_prem == '0;
          end else begin
            cf_d = cur + 3'd1;
          end
        end else begin
          sacc_d = sacc_new;
          bif_d  = bif1;
          cf_d   = cur;
        end
      end else begin
        in_pay_d = 1'b1;
        prem_d   = prem_base;
        if (prem_base != '0) begin
          prem_d              = prem_base - SIZE_BITS'(1);
          cmd_valid_o         = 1'b1;
          cmd_o.op            = CMD_PAY;
          cmd_o.end_of_packet = prem_base == SIZE_BITS'(1);
        end
      end
    end
  end

endmodule

// ----- design/hfe_queue.sv -----
module hfe_queue import hfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  cmd_t          mem_q [QueueDepth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = count_q != CW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(QueueDepth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(QueueDepth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- design/hfe_back.sv -----
module hfe_back import hfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [63:0] acc_q;
  logic [63:0] acc_base, acc_new;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic        out_free, pop, emit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (cmd_i.op == CMD_ACC) || out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign emit        = pop && (cmd_i.op != CMD_ACC);
  assign acc_base    = cmd_i.fresh ? '0 : acc_q;
  assign acc_new     = {acc_base[55:0], cmd_i.data};
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    out_item_d.field_index    = cmd_i.field_index;
    out_item_d.payload_length = cmd_i.payload_length;
    out_item_d.length_error   = cmd_i.length_error;
    out_item_d.end_of_packet  = cmd_i.end_of_packet;
    out_item_d.value          = 64'(cmd_i.data);
    case (cmd_i.op)
      CMD_NUM: begin
        out_item_d.item_kind = KIND_NUMERIC;
        out_item_d.value     = acc_new;
      end
      CMD_TEXT: out_item_d.item_kind = KIND_TEXT;
      default:  out_item_d.item_kind = KIND_PAYLOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        acc_q <= (cmd_i.op == CMD_NUM) ? '0 : acc_new;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

// ----- design/header_field_extractor_top.sv -----
// Header field extractor: byte-serial packet header parser.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one packet byte per
// transfer; start_packet marks the first byte of a new packet.
// Output channel (out_valid_o/out_ready_i, out_item_o) gives at most one
// result per byte: a completed numeric field, a text byte or a payload byte.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the header layout;
// it is always ready and should only be used while the block is idle.
// Throughput: one byte per cycle while the command queue has room, from the
// front parser that holds all sequencing state.
// Path: a result is registered in the command queue register, then in the
// output register, before out_valid_o presents it.
// The front hands classified commands to a two-entry queue; the back end
// assembles numeric values and drives the output register.
// Reset: layout returns to one numeric field of four bytes holding the size;
// parser, queue and output register are emptied.
// Receiver stall: the output register holds its result, the queue fills,
// and in_ready_o drops once the queue is full; nothing is lost.
module header_field_extractor_top import hfe_pkg::*; #(
  parameter int unsigned MAX_FIELDS      = MaxFieldsDef,
  parameter int unsigned MAX_FIELD_BYTES = MaxFieldBytesDef,
  parameter int unsigned SIZE_BITS       = SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  hfe_front #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
    .SIZE_BITS       (SIZE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  hfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  hfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench import hfe_pkg::*; ();

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned DrainPad   = 8;
  localparam int unsigned ParkCycles = 400;

  class field_parse_board;
    logic [3:0]  cnt_reg = 4'd1;
    logic [31:0] len_reg = 32'd4;
    logic [7:0]  text_reg = 8'd0;
    logic [2:0]  size_idx = 3'd0;

    bit          in_pay;
    logic [2:0]  cur_fld;
    logic [3:0]  byte_cnt;
    logic [63:0] acc;
    logic [31:0] tot_size;
    logic [31:0] pay_left;

    out_item_t   parsed[$];
    int          errors;

    function void write_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        CFG_FIELD_COUNT:   cnt_reg = data[3:0];
        CFG_FIELD_LENGTHS: len_reg = data;
        CFG_TEXT_MASK:     text_reg = data[7:0];
        CFG_SIZE_INDEX:    size_idx = data[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_fields();
      int unsigned c;
      c = cnt_reg;
      if (c == 0) c = 1;
      if (c > MaxFieldsDef) c = MaxFieldsDef;
      return c;
    endfunction

    function int unsigned fld_len(int unsigned i);
      int unsigned l;
      l = len_reg[4*i +: 4];
      if (l > MaxFieldBytesDef) l = MaxFieldBytesDef;
      return l;
    endfunction

    function int unsigned hdr_len();
      int unsigned s;
      s = 0;
      for (int unsigned i = 0; i < eff_fields(); i++) s += fld_len(i);
      return s;
    endfunction

    function void clear_packet();
      in_pay   = 0;
      cur_fld  = '0;
      byte_cnt = '0;
      acc      = '0;
      tot_size = '0;
      pay_left = '0;
    endfunction

    function bit close_header();
      int unsigned h;
      bit err;
      h = hdr_len();
      err = tot_size < h;
      pay_left = err ? 32'd0 : tot_size - h;
      in_pay = 1;
      return err;
    endfunction

    function void parse_byte(logic [7:0] data, bit start);
      out_item_t r;
      int unsigned n, cur, k, len;
      bit emit, txt;
      n = eff_fields();
      if (start) clear_packet();
      r = '0;
      emit = 0;
      if (!in_pay) begin
        cur = cur_fld;
        while (cur < n && fld_len(cur) == 0) cur++;
        if (cur >= n) begin
          void'(close_header());
        end else begin
          len = fld_len(cur);
          txt = text_reg[cur];
          acc = {acc[55:0], data};
          byte_cnt = byte_cnt + 4'd1;
          r.field_index = cur[2:0];
          if (txt) begin
            r.item_kind = KIND_TEXT;
            r.value = {56'd0, data};
            emit = 1;
          end
          if (byte_cnt == 0 || byte_cnt >= len) begin
            if (!txt) begin
              r.item_kind = KIND_NUMERIC;
              r.value = acc;
              emit = 1;
            end
            if (cur == size_idx) tot_size = acc[31:0];
            acc = '0;
            byte_cnt = '0;
            cur++;
            k = cur;
            while (k < n && fld_len(k) == 0) k++;
            if (k >= n) begin
              r.length_error = close_header();
              r.payload_length = pay_left;
              r.end_of_packet = (pay_left == 0);
              cur_fld = '0;
            end else begin
              cur_fld = cur[2:0];
            end
          end else begin
            cur_fld = cur[2:0];
          end
          if (emit) parsed.insert(parsed.size(), r);
          return;
        end
      end
      if (pay_left == 0) return;
      pay_left--;
      r.item_kind = KIND_PAYLOAD;
      r.field_index = '0;
      r.value = {56'd0, data};
      r.end_of_packet = (pay_left == 0);
      parsed.insert(parsed.size(), r);
    endfunction

    function void check_parsed(out_item_t got);
      out_item_t want;
      if (parsed.size() == 0) begin
        $error("unexpected result: %h", got);
        errors++;
        return;
      end
      want = parsed.pop_front();
      if (got.item_kind !== want.item_kind) begin
        $error("item_kind: expected %0d, actual %0d", want.item_kind, got.item_kind);
        errors++;
      end
      if (got.field_index !== want.field_index) begin
        $error("field_index: expected %0d, actual %0d", want.field_index, got.field_index);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %h, actual %h", want.value, got.value);
        errors++;
      end
      if (got.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, actual %0d",
               want.payload_length, got.payload_length);
        errors++;
      end
      if (got.length_error !== want.length_error) begin
        $error("length_error: expected %0b, actual %0b", want.length_error, got.length_error);
        errors++;
      end
      if (got.end_of_packet !== want.end_of_packet) begin
        $error("end_of_packet: expected %0b, actual %0b",
               want.end_of_packet, got.end_of_packet);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  field_parse_board board = new();

  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;
  int unsigned sent;
  int unsigned park_requests;
  int unsigned park_served;
  int unsigned hold_left;
  int unsigned quiet;

  header_field_extractor_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (out_valid && out_ready) board.check_parsed(out_item);
    if (park_served != park_requests) begin
      park_served++;
      hold_left = ParkCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task send_byte(logic [7:0] data, bit start);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: data, start_packet: start};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.parse_byte(data, start);
    sent++;
  endtask

  task write_cfg(cfg_reg_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task set_layout(logic [31:0] cnt, logic [31:0] lens, logic [31:0] mask,
                  logic [31:0] idx);
    write_cfg(CFG_FIELD_COUNT, cnt);
    write_cfg(CFG_FIELD_LENGTHS, lens);
    write_cfg(CFG_TEXT_MASK, mask);
    write_cfg(CFG_SIZE_INDEX, idx);
    cfg_valid <= 1'b0;
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.parsed.size() != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  task send_packet();
    int unsigned n, hdr, size, pay;
    int          l;
    logic [63:0] word;
    bit          first;
    n = board.eff_fields();
    hdr = board.hdr_len();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    if (hdr > 0 && $urandom_range(0, 7) == 0) size = $urandom_range(0, hdr - 1);
    else size = hdr + $urandom_range(0, 12);
    first = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      l = board.fld_len(i);
      word = {$urandom, $urandom};
      if (i == board.size_idx) word[31:0] = size;
      for (int j = l - 1; j >= 0; j--) begin
        send_byte(word[8*j +: 8], first);
        first = 1'b0;
      end
    end
    pay = (size > hdr) ? size - hdr : 0;
    if ($urandom_range(0, 7) == 0) pay = $urandom_range(0, pay);
    else pay += $urandom_range(0, 2);
    if (first) pay++;
    repeat (pay) begin
      send_byte(8'($urandom), first);
      first = 1'b0;
    end
  endtask

  task run_layout(logic [31:0] cnt, logic [31:0] lens, logic [31:0] mask,
                  logic [31:0] idx, int unsigned items, bit squeeze, bit idles);
    int unsigned target;
    wait_drained();
    set_layout(cnt, lens, mask, idx);
    in_idle_en = idles && ($urandom_range(0, 3) != 0);
    out_idle_en = idles && ($urandom_range(0, 3) != 0);
    if (squeeze) park_requests++;
    target = sent + items;
    while (sent < target) send_packet();
  endtask

  task random_layout(int unsigned items, bit squeeze);
    int unsigned c;
    c = $urandom_range(1, 8);
    run_layout(($urandom & 32'hFFFF_FFF0) | c, $urandom, $urandom,
               ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, c - 1), items, squeeze, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default layout: one 4-byte numeric size field
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b0);
    // size below header length
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    // restart mid-payload; left open so the next layout lands mid-packet
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h00, 1'b0);

    run_layout(32'd0, 32'h0000_0002, 32'h00, 32'd0, 150, 1'b0, 1'b1);
    run_layout(32'd15, 32'hFFFF_FFFF, 32'hFF, 32'd7, 300, 1'b0, 1'b1);
    run_layout(32'd4, 32'h0000_2801, 32'h04, 32'd3, 200, 1'b0, 1'b1);
    run_layout(32'd3, 32'h0000_0000, 32'h5A, 32'd0, 30, 1'b0, 1'b1);
    run_layout(32'd5, 32'h0001_2134, 32'h0A, 32'd6, 120, 1'b0, 1'b1);
    run_layout(32'd8, 32'h4321_0321, 32'h00, 32'd3, 120, 1'b0, 1'b1);
    run_layout(32'd8, 32'h8888_8888, 32'h00, 32'd0, 200, 1'b0, 1'b1);
    random_layout(150, 1'b0);
    random_layout(150, 1'b1);
    random_layout(150, 1'b0);
    random_layout(150, 1'b0);
    run_layout(32'd1, 32'h0000_0004, 32'h00, 32'd0, 150, 1'b0, 1'b0);

    wait_drained();
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
